// ===== src/mip_pkg.sv =====
// mip_pkg: types, codes and helpers shared by the marker interval profiler
// used by mip_div, mip_ctrl, mip_dp, the top level and the checker
package mip_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int STAMP_W        = 32;
    localparam int HZ_W           = 30;
    localparam int RATE_W         = 34;
    localparam int SHARE_W        = 10;
    localparam int CFG_IDX_W      = 1;
    localparam int DVD_W          = 42;

    localparam logic [1:0] KIND_MARKER = 2'd0;
    localparam logic [1:0] KIND_PAUSE  = 2'd1;
    localparam logic [1:0] KIND_FINAL  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] REC_REPLY   = 2'd0;
    localparam logic [1:0] REC_SLOT    = 2'd1;
    localparam logic [1:0] REC_KERNEL  = 2'd2;
    localparam logic [1:0] REC_SUMMARY = 2'd3;

    localparam logic [2:0] ERR_FULL   = 3'b001;
    localparam logic [2:0] ERR_NODATA = 3'b010;
    localparam logic [2:0] ERR_MODE   = 3'b100;

    localparam logic [1:0] MODE_CYCLES = 2'd0;
    localparam logic [1:0] MODE_US     = 2'd1;
    localparam logic [1:0] MODE_MS     = 2'd2;
    localparam logic [1:0] MODE_UNSUP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_UNIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_HZ    = 1'd1;

    localparam logic [HZ_W-1:0]    HZ_RESET     = 30'd80000000;
    localparam logic [DVD_W-1:0]   CYCLE_SCALE  = 42'd10;
    localparam logic [DVD_W-1:0]   US_RATE_X10  = 42'd10000000;
    localparam logic [DVD_W-1:0]   MS_RATE_X10  = 42'd10000;
    localparam logic [DVD_W-1:0]   PERMILLE     = 42'd1000;
    localparam logic [STAMP_W-1:0] STAMP_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         kind;
        logic [STAMP_W-1:0] timestamp;
        logic               kernel_enable;
        logic [STAMP_W-1:0] kernel_start_stamp;
        logic [STAMP_W-1:0] kernel_end_stamp;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         record_type;
        logic [2:0]         slot_number;
        logic [STAMP_W-1:0] interval_time;
        logic [SHARE_W-1:0] share_permille;
        logic [RATE_W-1:0]  loop_rate_x10;
        logic [2:0]         error_bits;
        logic [STAMP_W-1:0] rounds_done;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REPLY,
        ST_SUM,
        ST_TOTAL,
        ST_RATE,
        ST_RATE_WAIT,
        ST_SHARE,
        ST_SHARE_WAIT,
        ST_EMIT_SLOT,
        ST_KERN,
        ST_KERN_WAIT,
        ST_EMIT_KERN,
        ST_EMIT_SUM
    } state_t;

    typedef enum logic [1:0] {
        DIV_RATE,
        DIV_SLOT,
        DIV_KERN
    } div_sel_t;

    typedef enum logic [1:0] {
        OUT_REPLY,
        OUT_SLOT,
        OUT_KERN,
        OUT_SUM
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     sum_step;
        logic     total_upd;
        logic     div_start;
        div_sel_t div_sel;
        logic     rate_latch;
        logic     idx_inc;
        logic     load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic in_final;
        logic ptr_zero;
        logic idx_last;
        logic kern_en;
        logic div_done;
    } stat_t;

    function automatic logic [STAMP_W-1:0] sat_add(input logic [STAMP_W-1:0] a,
                                                   input logic [STAMP_W-1:0] b);
        logic [STAMP_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAMP_W] ? STAMP_MAX : s[STAMP_W-1:0];
    endfunction

endpackage

// ===== src/mip_div.sv =====
// mip_div: restoring divider, one quotient bit per cycle
// depends on mip_pkg for default widths; quotient is zero for a zero divisor
module mip_div #(
    parameter int DW = mip_pkg::DVD_W,
    parameter int VW = mip_pkg::STAMP_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] q_reg, q_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;
    logic          fits;

    assign rem_sh  = {rem_reg, q_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign fits    = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            q_next    = (divisor == '0) ? '0 : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = (divisor != '0);
            done_next = (divisor == '0);
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DW-2:0], fits};
            rem_next = fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/mip_ctrl.sv =====
// mip_ctrl: sequencer for the profiler, drives datapath commands
// depends on mip_pkg (state_t, cmd_t, stat_t)
module mip_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  mip_pkg::stat_t stat,
    output mip_pkg::cmd_t  cmd
);

    mip_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mip_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!stat.in_final)
                        state_next = mip_pkg::ST_REPLY;
                    else if (stat.ptr_zero)
                        state_next = mip_pkg::ST_EMIT_SUM;
                    else
                        state_next = mip_pkg::ST_SUM;
                end
            end
            mip_pkg::ST_REPLY:
                if (out_free) state_next = mip_pkg::ST_IDLE;
            mip_pkg::ST_SUM:
                if (stat.idx_last) state_next = mip_pkg::ST_TOTAL;
            mip_pkg::ST_TOTAL:      state_next = mip_pkg::ST_RATE;
            mip_pkg::ST_RATE:       state_next = mip_pkg::ST_RATE_WAIT;
            mip_pkg::ST_RATE_WAIT:
                if (stat.div_done) state_next = mip_pkg::ST_SHARE;
            mip_pkg::ST_SHARE:      state_next = mip_pkg::ST_SHARE_WAIT;
            mip_pkg::ST_SHARE_WAIT:
                if (stat.div_done) state_next = mip_pkg::ST_EMIT_SLOT;
            mip_pkg::ST_EMIT_SLOT:
            begin
                if (out_free)
                begin
                    if (!stat.idx_last)
                        state_next = mip_pkg::ST_SHARE;
                    else if (stat.kern_en)
                        state_next = mip_pkg::ST_KERN;
                    else
                        state_next = mip_pkg::ST_EMIT_SUM;
                end
            end
            mip_pkg::ST_KERN:       state_next = mip_pkg::ST_KERN_WAIT;
            mip_pkg::ST_KERN_WAIT:
                if (stat.div_done) state_next = mip_pkg::ST_EMIT_KERN;
            mip_pkg::ST_EMIT_KERN:
                if (out_free) state_next = mip_pkg::ST_EMIT_SUM;
            mip_pkg::ST_EMIT_SUM:
                if (out_free) state_next = mip_pkg::ST_IDLE;
            default:                state_next = mip_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.div_sel = mip_pkg::DIV_RATE;
        cmd.out_sel = mip_pkg::OUT_REPLY;
        in_ready = 1'b0;
        case (state_reg)
            mip_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            mip_pkg::ST_REPLY:
                cmd.load = out_free;
            mip_pkg::ST_SUM:
                cmd.sum_step = 1'b1;
            mip_pkg::ST_TOTAL:
                cmd.total_upd = 1'b1;
            mip_pkg::ST_RATE:
                cmd.div_start = 1'b1;
            mip_pkg::ST_RATE_WAIT:
                cmd.rate_latch = stat.div_done;
            mip_pkg::ST_SHARE:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = mip_pkg::DIV_SLOT;
            end
            mip_pkg::ST_EMIT_SLOT:
            begin
                cmd.load    = out_free;
                cmd.idx_inc = out_free;
                cmd.out_sel = mip_pkg::OUT_SLOT;
            end
            mip_pkg::ST_KERN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = mip_pkg::DIV_KERN;
            end
            mip_pkg::ST_EMIT_KERN:
            begin
                cmd.load    = out_free;
                cmd.out_sel = mip_pkg::OUT_KERN;
            end
            mip_pkg::ST_EMIT_SUM:
            begin
                cmd.load    = out_free;
                cmd.out_sel = mip_pkg::OUT_SUM;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mip_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/mip_dp.sv =====
// mip_dp: profiler state, slot store, config registers, divider and result register
// depends on mip_pkg and mip_div
module mip_dp #(
    parameter int SLOT_COUNT = mip_pkg::SLOT_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mip_pkg::in_item_t                  in_data,
    output mip_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [mip_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mip_pkg::HZ_W-1:0]           cfg_data,
    input  mip_pkg::cmd_t                      cmd,
    output mip_pkg::stat_t                     stat
);

    localparam int PW = $clog2(SLOT_COUNT + 1);
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SW = mip_pkg::STAMP_W;
    localparam int DW = mip_pkg::DVD_W;

    logic [SW-1:0] slot_reg [SLOT_COUNT];
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [SW-1:0] prev_reg, prev_next;
    logic          act_reg, act_next;
    logic [SW-1:0] total_reg, total_next;
    logic [SW-1:0] kern_reg, kern_next;
    logic [2:0]    err_reg, err_next;
    logic          closed_reg, closed_next;
    logic [SW-1:0] rounds_reg, rounds_next;
    logic          kern_en_reg, kern_en_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [SW-1:0] reply_reg, reply_next;
    logic [mip_pkg::RATE_W-1:0] rate_reg, rate_next;
    logic [1:0]    mode_reg;
    logic [mip_pkg::HZ_W-1:0] hz_reg;
    mip_pkg::out_item_t out_reg, out_next;

    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [SW-1:0] wr_val;
    logic [PW-1:0] ptr0;
    logic          act0;
    logic [SW-1:0] prev0;
    logic [2:0]    err0;
    logic [SW-1:0] slot_rd;
    logic [PW-1:0] ptr_m1;
    logic [DW-1:0] dvd;
    logic [DW-1:0] quo;
    logic          div_done;

    assign ptr_m1  = ptr_reg - 1'b1;
    assign slot_rd = slot_reg[idx_reg[IW-1:0]];

    // a marker after a closed round starts from a flushed round
    assign ptr0  = closed_reg ? '0 : ptr_reg;
    assign act0  = closed_reg ? 1'b0 : act_reg;
    assign prev0 = closed_reg ? '0 : prev_reg;
    assign err0  = closed_reg ? '0 : err_reg;

    always_comb
    begin
        ptr_next     = ptr_reg;
        prev_next    = prev_reg;
        act_next     = act_reg;
        total_next   = total_reg;
        kern_next    = kern_reg;
        err_next     = err_reg;
        closed_next  = closed_reg;
        rounds_next  = rounds_reg;
        kern_en_next = kern_en_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        reply_next   = reply_reg;
        rate_next    = rate_reg;
        wr_en        = 1'b0;
        wr_idx       = ptr_m1[IW-1:0];
        wr_val       = in_data.timestamp - prev_reg;

        if (cmd.accept)
        begin
            reply_next = '0;
            case (in_data.kind)
                mip_pkg::KIND_MARKER:
                begin
                    ptr_next    = ptr0;
                    act_next    = act0;
                    prev_next   = prev0;
                    err_next    = err0;
                    closed_next = 1'b0;
                    if (closed_reg)
                        total_next = '0;
                    if (ptr0 >= PW'(SLOT_COUNT))
                        err_next = err0 | mip_pkg::ERR_FULL;
                    else if (!act0 || ptr0 == '0)
                    begin
                        ptr_next  = ptr0 + 1'b1;
                        prev_next = in_data.timestamp;
                        act_next  = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        reply_next = wr_val;
                        ptr_next   = ptr0 + 1'b1;
                        prev_next  = in_data.timestamp;
                    end
                end
                mip_pkg::KIND_PAUSE:
                begin
                    if (act_reg && ptr_reg != '0)
                    begin
                        wr_en      = 1'b1;
                        reply_next = wr_val;
                        prev_next  = '0;
                        act_next   = 1'b0;
                    end
                end
                mip_pkg::KIND_FINAL:
                begin
                    rounds_next  = rounds_reg + 1'b1;
                    kern_en_next = in_data.kernel_enable;
                    rate_next    = '0;
                    sum_next     = '0;
                    idx_next     = '0;
                    if (ptr_reg == '0)
                        err_next = err_reg | mip_pkg::ERR_NODATA;
                    else
                    begin
                        wr_en       = act_reg;
                        closed_next = 1'b1;
                        if (in_data.kernel_enable)
                        begin
                            prev_next = in_data.kernel_start_stamp;
                            act_next  = 1'b1;
                            kern_next = in_data.kernel_end_stamp
                                        - in_data.kernel_start_stamp;
                        end
                        if (mode_reg == mip_pkg::MODE_UNSUP)
                            err_next = err_reg | mip_pkg::ERR_MODE;
                    end
                end
                default:
                begin
                    reply_next = '0;
                end
            endcase
        end

        if (cmd.sum_step)
        begin
            sum_next = mip_pkg::sat_add(sum_reg, slot_rd);
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.total_upd)
        begin
            total_next = mip_pkg::sat_add(total_reg,
                kern_en_reg ? mip_pkg::sat_add(sum_reg, kern_reg) : sum_reg);
            idx_next = '0;
        end
        if (cmd.idx_inc)
            idx_next = idx_reg + 1'b1;
        if (cmd.rate_latch)
            rate_next = quo[mip_pkg::RATE_W-1:0];
    end

    // dividend: loop rate scale, or part times 1000 for a share
    always_comb
    begin
        dvd = '0;
        case (cmd.div_sel)
            mip_pkg::DIV_RATE:
            begin
                case (mode_reg)
                    mip_pkg::MODE_CYCLES: dvd = DW'(hz_reg) * mip_pkg::CYCLE_SCALE;
                    mip_pkg::MODE_US:     dvd = mip_pkg::US_RATE_X10;
                    mip_pkg::MODE_MS:     dvd = mip_pkg::MS_RATE_X10;
                    default:              dvd = '0;
                endcase
            end
            mip_pkg::DIV_SLOT: dvd = DW'(slot_rd) * mip_pkg::PERMILLE;
            mip_pkg::DIV_KERN: dvd = DW'(kern_reg) * mip_pkg::PERMILLE;
            default:           dvd = '0;
        endcase
    end

    mip_div #(
        .DW(DW),
        .VW(SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        out_next = out_reg;
        if (cmd.load)
        begin
            out_next.slot_number    = '0;
            out_next.interval_time  = reply_reg;
            out_next.share_permille = '0;
            out_next.loop_rate_x10  = '0;
            out_next.error_bits     = err_reg;
            out_next.rounds_done    = rounds_reg;
            out_next.last           = 1'b0;
            out_next.record_type    = mip_pkg::REC_REPLY;
            case (cmd.out_sel)
                mip_pkg::OUT_REPLY:
                    out_next.last = 1'b1;
                mip_pkg::OUT_SLOT:
                begin
                    out_next.record_type    = mip_pkg::REC_SLOT;
                    out_next.slot_number    = 3'(idx_reg);
                    out_next.interval_time  = slot_rd;
                    out_next.share_permille = quo[mip_pkg::SHARE_W-1:0];
                end
                mip_pkg::OUT_KERN:
                begin
                    out_next.record_type    = mip_pkg::REC_KERNEL;
                    out_next.interval_time  = kern_reg;
                    out_next.share_permille = quo[mip_pkg::SHARE_W-1:0];
                end
                mip_pkg::OUT_SUM:
                begin
                    out_next.record_type   = mip_pkg::REC_SUMMARY;
                    out_next.interval_time = total_reg;
                    out_next.loop_rate_x10 = rate_reg;
                    out_next.last          = 1'b1;
                end
                default:
                    out_next.last = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_reg[i] <= '0;
            ptr_reg    <= '0;
            prev_reg   <= '0;
            act_reg    <= 1'b0;
            total_reg  <= '0;
            kern_reg   <= '0;
            err_reg    <= '0;
            closed_reg <= 1'b0;
            rounds_reg <= '0;
            mode_reg   <= mip_pkg::MODE_CYCLES;
            hz_reg     <= mip_pkg::HZ_RESET;
        end
        else
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                if (wr_en && wr_idx == IW'(i))
                    slot_reg[i] <= wr_val;
            ptr_reg    <= ptr_next;
            prev_reg   <= prev_next;
            act_reg    <= act_next;
            total_reg  <= total_next;
            kern_reg   <= kern_next;
            err_reg    <= err_next;
            closed_reg <= closed_next;
            rounds_reg <= rounds_next;
            if (cfg_we && cfg_index == mip_pkg::REG_TIME_UNIT)
                mode_reg <= cfg_data[1:0];
            if (cfg_we && cfg_index == mip_pkg::REG_CPU_HZ)
                hz_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        kern_en_reg <= kern_en_next;
        idx_reg     <= idx_next;
        sum_reg     <= sum_next;
        reply_reg   <= reply_next;
        rate_reg    <= rate_next;
        out_reg     <= out_next;
    end

    assign out_data = out_reg;

    assign stat.in_final = (in_data.kind == mip_pkg::KIND_FINAL);
    assign stat.ptr_zero = (ptr_reg == '0);
    assign stat.idx_last = (idx_reg == ptr_m1);
    assign stat.kern_en  = kern_en_reg;
    assign stat.div_done = div_done;

endmodule

// ===== src/marker_interval_profiler_core.sv =====
// marker_interval_profiler_core: top level of the marker interval profiler
// depends on mip_pkg, mip_ctrl, mip_dp (with mip_div)
//
//  channel | signals                          | carries
//  --------+----------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data      | one event (marker/pause/finalize)
//  out     | out_valid, out_ready, out_data   | one record per transaction
//  cfg     | cfg_we, cfg_index, cfg_data      | register write, no wait
//
// finalize with P slots emits P slot records, a kernel record if enabled and a
// summary; the loop rate and each share go through the 42-step shared divider
// reset is asynchronous, clears slot, round and sequencer state and restores
// config defaults; the record and working registers are not reset
// a stalled out_ready holds the record and the sequencer in reply and emit states
module marker_interval_profiler_core #(
    parameter int SLOT_COUNT = mip_pkg::SLOT_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mip_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mip_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [mip_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mip_pkg::HZ_W-1:0]      cfg_data
);

    mip_pkg::cmd_t  cmd;
    mip_pkg::stat_t stat;

    mip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mip_dp #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== src/mip_checker.sv =====
// mip_checker: port-level checks for the profiler top level
// depends on mip_pkg; bound to marker_interval_profiler_core
module mip_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input mip_pkg::out_item_t out_data
);

    // a stalled record holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("record changed while stalled");

    // in_ready drops after every accepted event
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on back-to-back cycles");

    // more records pending, so no new event
    a_no_accept_mid_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !in_ready)
        else $error("input ready while an event is unfinished");

    a_rate_only_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.record_type != mip_pkg::REC_SUMMARY
        |-> out_data.loop_rate_x10 == '0)
        else $error("loop rate outside summary");

    a_reply_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.record_type == mip_pkg::REC_REPLY |-> out_data.last)
        else $error("reply not marked last");

endmodule

bind marker_interval_profiler_core mip_checker u_mip_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== verif/tb_marker_interval_profiler_core.sv =====
// tb_marker_interval_profiler_core: self-checking bench for the marker interval profiler
// drives events and register writes, predicts every record; depends on mip_pkg and the core
`timescale 1ns / 100ps

module tb_marker_interval_profiler_core;

    localparam int NSLOT = mip_pkg::SLOT_COUNT_DEF;

    // profiler state mirror and record predictor
    class profile_board;
        logic [31:0] slot_t [NSLOT];
        int unsigned ptr;
        logic [31:0] prev;
        bit          active;
        logic [31:0] total;
        logic [31:0] kern_t;
        logic [2:0]  errs;
        bit          closed;
        logic [31:0] rounds;
        logic [1:0]  mode;
        logic [29:0] hz;
        mip_pkg::out_item_t pending[$];
        int          mismatches;

        function new();
            foreach (slot_t[i]) slot_t[i] = '0;
            ptr = 0; prev = '0; active = 0; total = '0; kern_t = '0;
            errs = '0; closed = 0; rounds = '0;
            mode = mip_pkg::MODE_CYCLES; hz = mip_pkg::HZ_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [mip_pkg::CFG_IDX_W-1:0] idx, logic [29:0] val);
            if (idx == mip_pkg::REG_TIME_UNIT) mode = val[1:0];
            else hz = val;
        endfunction

        function void push(logic [1:0] t, logic [2:0] s, logic [31:0] iv,
                           logic [9:0] sh, logic [33:0] r, bit l);
            mip_pkg::out_item_t o;
            o.record_type = t; o.slot_number = s; o.interval_time = iv;
            o.share_permille = sh; o.loop_rate_x10 = r; o.error_bits = errs;
            o.rounds_done = rounds; o.last = l;
            pending.push_back(o);
        endfunction

        function logic [31:0] sadd(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function logic [9:0] permille(logic [31:0] part);
            logic [63:0] p;
            if (total == 0) return '0;
            p = (64'(part) * 64'd1000) / 64'(total);
            return p[9:0];
        endfunction

        function void note_event(mip_pkg::in_item_t e);
            logic [31:0] reply, sum;
            logic [63:0] rate;
            reply = '0; rate = '0;
            if (e.kind == mip_pkg::KIND_MARKER)
            begin
                if (closed)
                begin
                    errs = '0; prev = '0; active = 0; total = '0; ptr = 0; closed = 0;
                end
                if (ptr >= NSLOT) errs |= mip_pkg::ERR_FULL;
                else if (!active || ptr == 0)
                begin
                    ptr++; prev = e.timestamp; active = 1;
                end
                else
                begin
                    reply = e.timestamp - prev;
                    slot_t[ptr-1] = reply; ptr++; prev = e.timestamp;
                end
                push(mip_pkg::REC_REPLY, 0, reply, 0, 0, 1);
            end
            else if (e.kind == mip_pkg::KIND_PAUSE)
            begin
                if (active && ptr != 0 && ptr <= NSLOT)
                begin
                    reply = e.timestamp - prev;
                    slot_t[ptr-1] = reply; prev = '0; active = 0;
                end
                push(mip_pkg::REC_REPLY, 0, reply, 0, 0, 1);
            end
            else if (e.kind != mip_pkg::KIND_FINAL)
            begin
                push(mip_pkg::REC_REPLY, 0, 0, 0, 0, 1);
            end
            else
            begin
                rounds++;
                if (ptr == 0 || ptr > NSLOT)
                begin
                    errs |= mip_pkg::ERR_NODATA;
                    push(mip_pkg::REC_SUMMARY, 0, total, 0, 0, 1);
                    return;
                end
                if (active) slot_t[ptr-1] = e.timestamp - prev;
                if (e.kernel_enable)
                begin
                    prev = e.kernel_start_stamp; active = 1;
                    kern_t = e.kernel_end_stamp - e.kernel_start_stamp;
                end
                sum = '0;
                for (int i = 0; i < ptr; i++) sum = sadd(sum, slot_t[i]);
                if (e.kernel_enable) sum = sadd(sum, kern_t);
                total = sadd(total, sum);
                if (total != 0)
                begin
                    if (mode == mip_pkg::MODE_CYCLES)
                        rate = (64'(hz) * 64'd10) / 64'(total);
                    else if (mode == mip_pkg::MODE_US) rate = 64'd10000000 / 64'(total);
                    else if (mode == mip_pkg::MODE_MS) rate = 64'd10000 / 64'(total);
                end
                if (mode == mip_pkg::MODE_UNSUP) errs |= mip_pkg::ERR_MODE;
                closed = 1;
                for (int i = 0; i < ptr; i++)
                    push(mip_pkg::REC_SLOT, 3'(i), slot_t[i], permille(slot_t[i]), 0, 0);
                if (e.kernel_enable)
                    push(mip_pkg::REC_KERNEL, 0, kern_t, permille(kern_t), 0, 0);
                push(mip_pkg::REC_SUMMARY, 0, total, 0, rate[33:0], 1);
            end
        endfunction

        function void check_record(mip_pkg::out_item_t got);
            mip_pkg::out_item_t w;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected record %p", got);
                return;
            end
            w = pending.pop_front();
            if (got !== w)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("record mismatch: expected %p actual %p", w, got);
            end
        endfunction
    endclass

    logic clk, rst_n, in_valid, in_ready, out_valid, out_ready, cfg_we;
    mip_pkg::in_item_t in_data;
    mip_pkg::out_item_t out_data;
    logic [mip_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mip_pkg::HZ_W-1:0] cfg_data;
    profile_board board;

    marker_interval_profiler_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // valid stays high into the next transaction when no idle cycles are drawn
    task automatic send_event(mip_pkg::in_item_t e);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1; in_data <= e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_event(e);
        @(negedge clk);
    endtask

    task automatic ev(logic [1:0] k, logic [31:0] ts, bit ke = 0,
                      logic [31:0] ks = 0, logic [31:0] kend = 0);
        mip_pkg::in_item_t e;
        e.kind = k; e.timestamp = ts; e.kernel_enable = ke;
        e.kernel_start_stamp = ks; e.kernel_end_stamp = kend;
        send_event(e);
    endtask

    task automatic settle();
        in_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic write_reg(logic [mip_pkg::CFG_IDX_W-1:0] idx,
                             logic [mip_pkg::HZ_W-1:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        board.write_reg(idx, val);
        @(negedge clk);
    endtask

    // one profiling round of random markers and pauses, sometimes an unknown event, then one or two finalizes
    task automatic random_round();
        int n;
        logic [31:0] ts;
        n = $urandom_range(1, 9);
        ts = $urandom;
        for (int i = 0; i < n; i++)
        begin
            ts += ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 5000));
            if ($urandom_range(0, 7) == 0) ev(mip_pkg::KIND_PAUSE, ts);
            else ev(mip_pkg::KIND_MARKER, ts);
        end
        if ($urandom_range(0, 9) == 0) ev(mip_pkg::KIND_NONE, $urandom);
        ev(mip_pkg::KIND_FINAL, ts + 32'($urandom_range(0, 100000)),
           1'($urandom_range(0, 1)), $urandom, $urandom);
        if ($urandom_range(0, 5) == 0)
            ev(mip_pkg::KIND_FINAL, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom);
    endtask

    // record sink with random stalls
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready) out_ready <= 0;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) board.check_record(out_data);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!out_ready)
            begin
                repeat ($urandom_range(0, 6)) @(negedge clk);
                out_ready <= 1;
            end
        end
    end

    initial
    begin
        board = new();
        rst_n = 0; in_valid = 0; in_data = '0; out_ready = 1;
        cfg_we = 0; cfg_index = '0; cfg_data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: nodata, unknown kind, pause idle, extremes, full slots, rollover
        ev(mip_pkg::KIND_FINAL, 32'h0);
        ev(mip_pkg::KIND_NONE, 32'hFFFF_FFFF);
        ev(mip_pkg::KIND_PAUSE, 32'h1234);
        ev(mip_pkg::KIND_MARKER, 32'hFFFF_FFF0);
        ev(mip_pkg::KIND_MARKER, 32'h0000_0010);
        for (int i = 0; i < 8; i++) ev(mip_pkg::KIND_MARKER, 32'(32'h100 * (i + 1)));
        ev(mip_pkg::KIND_PAUSE, 32'hFFFF_FFFF);
        ev(mip_pkg::KIND_FINAL, 32'h5555_5555, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        ev(mip_pkg::KIND_FINAL, 32'hAAAA_AAAA, 1, 32'h0, 32'hFFFF_FFFF);
        ev(mip_pkg::KIND_MARKER, 32'h10);
        ev(mip_pkg::KIND_FINAL, 32'h10);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(mip_pkg::REG_TIME_UNIT, 30'(mip_pkg::MODE_US));
                    write_reg(mip_pkg::REG_CPU_HZ, 30'd1);
                end
                1: write_reg(mip_pkg::REG_TIME_UNIT, 30'(mip_pkg::MODE_MS));
                2: write_reg(mip_pkg::REG_TIME_UNIT, 30'(mip_pkg::MODE_UNSUP));
                3:
                begin
                    write_reg(mip_pkg::REG_TIME_UNIT, 30'(mip_pkg::MODE_CYCLES));
                    write_reg(mip_pkg::REG_CPU_HZ, 30'd1000000000);
                end
                4: write_reg(mip_pkg::REG_CPU_HZ, 30'h3FFF_FFFF);
                default: write_reg(mip_pkg::REG_CPU_HZ, 30'($urandom_range(1, 1000000000)));
            endcase
            for (int r = 0; r < 9; r++) random_round();
            if (ph == 2)
                for (int r = 0; r < 8; r++)
                    ev(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                       $urandom, $urandom);
            settle();
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb_marker_interval_profiler_core passed");
        else
            $display("tb_marker_interval_profiler_core failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_marker_interval_profiler_core failed");
        $finish;
    end
endmodule
